[rtl/pal_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types and constants for the positional array list.
// ----------------------------------------------------------------------------
package pal_pkg;

    localparam int DEPTH_DEF      = 128;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int ACTION_W = 3;
    localparam int POS_W    = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 8;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT       = 3'd0,
        ACT_INSERT_FIRST = 3'd1,
        ACT_INSERT_LAST  = 3'd2,
        ACT_DELETE       = 3'd3,
        ACT_REPLACE      = 3'd4,
        ACT_SEARCH       = 3'd5,
        ACT_READ         = 3'd6,
        ACT_CLEAR        = 3'd7
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_INDEX = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_COLLECT
    } fsm_state_t;

    typedef struct packed {
        logic shift_up;
        logic shift_down;
        logic write;
        logic capture;
        logic search;
    } cell_ctl_t;

endpackage

[rtl/pal_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_cell
// One list entry: holds a word, takes it from a neighbor on shifts, and
// registers its read tap and search hit for the result stage.
// ----------------------------------------------------------------------------
module pal_cell #(
    parameter int DATA_WIDTH = pal_pkg::DATA_WIDTH_DEF,
    parameter int CMP_W      = 8,
    parameter int INDEX      = 0
) (
    input  logic                  clk,
    input  pal_pkg::cell_ctl_t    ctl,
    input  logic [CMP_W-1:0]      pos,
    input  logic [CMP_W-1:0]      count,
    input  logic [DATA_WIDTH-1:0] value,
    input  logic [DATA_WIDTH-1:0] left_word,
    input  logic [DATA_WIDTH-1:0] right_word,
    output logic [DATA_WIDTH-1:0] word,
    output logic [DATA_WIDTH-1:0] tap,
    output logic                  hit
);

    localparam logic [CMP_W-1:0] MY_INDEX = CMP_W'(INDEX);

    logic [DATA_WIDTH-1:0] word_reg;
    logic [DATA_WIDTH-1:0] word_next;
    logic [DATA_WIDTH-1:0] tap_reg;
    logic [DATA_WIDTH-1:0] tap_next;
    logic                  hit_reg;
    logic                  hit_next;

    logic at_pos;
    logic above_pos;

    assign at_pos    = (MY_INDEX == pos);
    assign above_pos = (MY_INDEX > pos);

    always_comb
    begin
        word_next = word_reg;
        if (ctl.write && at_pos)
        begin
            word_next = value;
        end
        else if (ctl.shift_up && above_pos)
        begin
            word_next = left_word;
        end
        else if (ctl.shift_down && (at_pos || above_pos))
        begin
            word_next = right_word;
        end
    end

    assign tap_next = (ctl.capture && at_pos) ? word_reg : '0;
    assign hit_next = ctl.search && (MY_INDEX < count) && (word_reg == value);

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        tap_reg  <= tap_next;
        hit_reg  <= hit_next;
    end

    assign word = word_reg;
    assign tap  = tap_reg;
    assign hit  = hit_reg;

endmodule

[rtl/pal_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_ctrl
// Action decoder, fill count, handshake sequencing and result register.
// ----------------------------------------------------------------------------
module pal_ctrl #(
    parameter int DEPTH      = pal_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = pal_pkg::DATA_WIDTH_DEF,
    parameter int CNT_W      = 8,
    parameter int CMP_W      = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pal_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pal_pkg::M_TDATA_W-1:0]  m_tdata,
    output pal_pkg::cell_ctl_t             ctl,
    output logic [CMP_W-1:0]               pos,
    output logic [CMP_W-1:0]               count,
    output logic [DATA_WIDTH-1:0]          value,
    input  logic [DATA_WIDTH-1:0]          data_or,
    input  logic                           found_or
);

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    pal_pkg::fsm_state_t state_reg;
    pal_pkg::fsm_state_t state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    pal_pkg::status_t    status_reg;
    pal_pkg::status_t    status_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [pal_pkg::M_TDATA_W-1:0] out_data_reg;
    logic [pal_pkg::M_TDATA_W-1:0] out_data_next;

    pal_pkg::action_t    action;
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    count_ext;
    logic [CMP_W-1:0]    eff_pos;
    logic                accept;
    logic                collect;
    pal_pkg::status_t    decode_status;
    logic [CNT_W-1:0]    decode_count;
    pal_pkg::cell_ctl_t  decode_ctl;

    assign action    = pal_pkg::action_t'(s_tdata[2:0]);
    assign pos_ext   = CMP_W'(s_tdata[10:3]);
    assign count_ext = CMP_W'(count_reg);
    assign value     = DATA_WIDTH'(s_tdata[42:11]);
    assign accept    = s_tvalid && s_tready;

    // action decoder
    always_comb
    begin
        decode_ctl    = '0;
        decode_status = pal_pkg::ST_OK;
        decode_count  = count_reg;
        eff_pos       = pos_ext;
        unique case (action) inside
            pal_pkg::ACT_INSERT, pal_pkg::ACT_INSERT_FIRST, pal_pkg::ACT_INSERT_LAST:
            begin
                if (action == pal_pkg::ACT_INSERT_FIRST)
                begin
                    eff_pos = '0;
                end
                else if (action == pal_pkg::ACT_INSERT_LAST)
                begin
                    eff_pos = count_ext;
                end
                if (count_reg == FULL_COUNT)
                begin
                    decode_status = pal_pkg::ST_FULL;
                end
                else if (eff_pos > count_ext)
                begin
                    decode_status = pal_pkg::ST_INDEX;
                end
                else
                begin
                    decode_ctl.shift_up = 1'b1;
                    decode_ctl.write    = 1'b1;
                    decode_count        = count_reg + CNT_W'(1);
                end
            end
            pal_pkg::ACT_DELETE, pal_pkg::ACT_REPLACE, pal_pkg::ACT_READ:
            begin
                if (count_reg == '0)
                begin
                    decode_status = pal_pkg::ST_EMPTY;
                end
                else if (pos_ext >= count_ext)
                begin
                    decode_status = pal_pkg::ST_INDEX;
                end
                else if (action == pal_pkg::ACT_DELETE)
                begin
                    decode_ctl.capture    = 1'b1;
                    decode_ctl.shift_down = 1'b1;
                    decode_count          = count_reg - CNT_W'(1);
                end
                else if (action == pal_pkg::ACT_REPLACE)
                begin
                    decode_ctl.write = 1'b1;
                end
                else
                begin
                    decode_ctl.capture = 1'b1;
                end
            end
            pal_pkg::ACT_SEARCH:
            begin
                if (count_reg == '0)
                begin
                    decode_status = pal_pkg::ST_EMPTY;
                end
                else
                begin
                    decode_ctl.search = 1'b1;
                end
            end
            pal_pkg::ACT_CLEAR:
            begin
                decode_count = '0;
            end
            default:
            begin
                decode_count = count_reg;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pal_pkg::FSM_IDLE:
            begin
                if (accept)
                begin
                    state_next = pal_pkg::FSM_COLLECT;
                end
            end
            pal_pkg::FSM_COLLECT:
            begin
                state_next = pal_pkg::FSM_IDLE;
            end
            default:
            begin
                state_next = pal_pkg::FSM_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        s_tready = 1'b0;
        collect  = 1'b0;
        unique case (state_reg)
            pal_pkg::FSM_IDLE:
            begin
                s_tready = !out_valid_reg || m_tready;
            end
            pal_pkg::FSM_COLLECT:
            begin
                collect = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign ctl         = accept ? decode_ctl : '0;
    assign pos         = eff_pos;
    assign count       = count_ext;
    assign count_next  = accept ? decode_count : count_reg;
    assign status_next = accept ? decode_status : status_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (collect)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // from bit 0: status, data_out, found, count, is_empty, is_full, zero fill
    always_comb
    begin
        out_data_next = out_data_reg;
        if (collect)
        begin
            out_data_next = {3'b000,
                             (count_reg == FULL_COUNT),
                             (count_reg == '0),
                             pal_pkg::COUNT_W'(count_reg),
                             found_or,
                             pal_pkg::VALUE_W'(data_or),
                             status_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pal_pkg::FSM_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[rtl/positional_array_list_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_list_top
// Ordered list of signed words kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// In the cycle an item is accepted every cell of the row writes, shifts from
// its neighbor or holds, and latches its read tap and search hit; in the next
// cycle the taps and hits of all DEPTH cells are OR-reduced into the result
// register. A new item is taken only once the previous result has been formed
// and the result register is free or being drained, so the block does not take
// a new item before it is through with the last one. No memory sweep follows
// reset.
module positional_array_list_top #(
    parameter int DEPTH      = pal_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = pal_pkg::DATA_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // action, position, value, zero fill
    input  logic [pal_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status, data_out, found, count, is_empty, is_full, zero fill
    output logic [pal_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > pal_pkg::POS_W) ? CNT_W : pal_pkg::POS_W;

    pal_pkg::cell_ctl_t    ctl;
    logic [CMP_W-1:0]      pos;
    logic [CMP_W-1:0]      count;
    logic [DATA_WIDTH-1:0] value;
    logic [DATA_WIDTH-1:0] words [DEPTH];
    logic [DATA_WIDTH-1:0] taps  [DEPTH];
    logic [DEPTH-1:0]      hits;
    logic [DEPTH-1:0]      tap_bits [DATA_WIDTH];
    logic [DATA_WIDTH-1:0] data_or;
    logic                  found_or;

    pal_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .CNT_W      (CNT_W),
        .CMP_W      (CMP_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .ctl      (ctl),
        .pos      (pos),
        .count    (count),
        .value    (value),
        .data_or  (data_or),
        .found_or (found_or)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_word;
        logic [DATA_WIDTH-1:0] right_word;

        if (i == 0)
        begin : g_first
            assign left_word = '0;
        end
        else
        begin : g_inner_l
            assign left_word = words[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_word = '0;
        end
        else
        begin : g_inner_r
            assign right_word = words[i+1];
        end

        pal_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CMP_W      (CMP_W),
            .INDEX      (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .pos        (pos),
            .count      (count),
            .value      (value),
            .left_word  (left_word),
            .right_word (right_word),
            .word       (words[i]),
            .tap        (taps[i]),
            .hit        (hits[i])
        );
    end

    // bitwise OR over the registered taps of the row
    for (genvar b = 0; b < DATA_WIDTH; b++)
    begin : g_bit
        for (genvar j = 0; j < DEPTH; j++)
        begin : g_col
            assign tap_bits[b][j] = taps[j][b];
        end
        assign data_or[b] = |tap_bits[b];
    end

    assign found_or = |hits;

endmodule

[verif/list_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_result_checker
// Watches both stream channels of the positional array list, keeps a shadow
// copy of the list, works out the result of every accepted action and
// compares each returned result field by field, in order.
// ----------------------------------------------------------------------------
module list_result_checker #(
    parameter int DEPTH = pal_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [pal_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [pal_pkg::M_TDATA_W-1:0] m_tdata,
    output int                            error_count,
    output int                            outstanding
);

    typedef struct packed {
        pal_pkg::status_t status;
        logic [31:0]      data_out;
        logic             found;
        logic [7:0]       count;
        logic             is_empty;
        logic             is_full;
    } list_result_t;

    logic [31:0]  shadow_words [DEPTH];
    int           shadow_len = 0;
    list_result_t pending_results [$];

    function automatic list_result_t apply_list_action(
        input pal_pkg::action_t act,
        input logic [7:0]       pos_in,
        input logic [31:0]      val
    );
        list_result_t r;
        int           pos;
        int           i;
        r = '0;
        r.status = pal_pkg::ST_OK;
        pos = int'(pos_in);
        case (act) inside
            pal_pkg::ACT_INSERT, pal_pkg::ACT_INSERT_FIRST, pal_pkg::ACT_INSERT_LAST:
            begin
                if (act == pal_pkg::ACT_INSERT_FIRST)
                    pos = 0;
                else if (act == pal_pkg::ACT_INSERT_LAST)
                    pos = shadow_len;
                if (shadow_len >= DEPTH)
                    r.status = pal_pkg::ST_FULL;
                else if (pos > shadow_len)
                    r.status = pal_pkg::ST_INDEX;
                else
                begin
                    for (i = shadow_len; i > pos; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[pos] = val;
                    shadow_len++;
                end
            end
            pal_pkg::ACT_DELETE, pal_pkg::ACT_REPLACE, pal_pkg::ACT_READ:
            begin
                if (shadow_len == 0)
                    r.status = pal_pkg::ST_EMPTY;
                else if (pos >= shadow_len)
                    r.status = pal_pkg::ST_INDEX;
                else if (act == pal_pkg::ACT_DELETE)
                begin
                    r.data_out = shadow_words[pos];
                    for (i = pos; i + 1 < shadow_len; i++)
                        shadow_words[i] = shadow_words[i+1];
                    shadow_len--;
                end
                else if (act == pal_pkg::ACT_REPLACE)
                    shadow_words[pos] = val;
                else
                    r.data_out = shadow_words[pos];
            end
            pal_pkg::ACT_SEARCH:
            begin
                if (shadow_len == 0)
                    r.status = pal_pkg::ST_EMPTY;
                else
                    for (i = 0; i < shadow_len; i++)
                        if (shadow_words[i] == val)
                            r.found = 1'b1;
            end
            default:
                shadow_len = 0;
        endcase
        r.count    = shadow_len[7:0];
        r.is_empty = (shadow_len == 0);
        r.is_full  = (shadow_len == DEPTH);
        return r;
    endfunction

    task automatic report_field(input string field_name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, field_name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        list_result_t want;
        list_result_t got;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.status   = pal_pkg::status_t'(m_tdata[1:0]);
                got.data_out = m_tdata[33:2];
                got.found    = m_tdata[34];
                got.count    = m_tdata[42:35];
                got.is_empty = m_tdata[43];
                got.is_full  = m_tdata[44];
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_tdata);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    report_field("status", 32'(want.status), 32'(got.status));
                    report_field("data_out", want.data_out, got.data_out);
                    report_field("found", 32'(want.found), 32'(got.found));
                    report_field("count", 32'(want.count), 32'(got.count));
                    report_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
                    report_field("is_full", 32'(want.is_full), 32'(got.is_full));
                end
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(
                    apply_list_action(pal_pkg::action_t'(s_tdata[2:0]),
                                      s_tdata[10:3],
                                      s_tdata[42:11]));
        end
        outstanding <= pending_results.size();
    end

endmodule

[verif/positional_array_list_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_list_top_tb
// Drives list actions into the positional array list: a directed pass over
// the empty and index cases and the word extremes, then phases that grow,
// churn and shrink the list with bursty input and a stalling consumer.
// ----------------------------------------------------------------------------
module positional_array_list_top_tb;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 1600;

    typedef enum int {GROW_PHASE, MIXED_PHASE, SHRINK_PHASE} phase_t;
    typedef enum int {ALWAYS_READY, COIN_FLIP, EVERY_KTH, MOSTLY_READY} stall_style_t;

    logic                          clk;
    logic                          rst_n    = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [pal_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [pal_pkg::M_TDATA_W-1:0] m_tdata;
    int                            error_count;
    int                            outstanding;

    logic [31:0] value_pool [16];
    int          burst_left = 0;

    positional_array_list_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    list_result_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic offer_item(input pal_pkg::action_t act, input logic [7:0] pos,
                              input logic [31:0] val);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 10);
        end
        burst_left--;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, val, pos, act};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic pal_pkg::action_t pick_action(input phase_t phase);
        int r;
        r = $urandom_range(0, 99);
        case (phase)
            GROW_PHASE:
                return r < 20 ? pal_pkg::ACT_INSERT :
                       r < 50 ? pal_pkg::ACT_INSERT_FIRST :
                       r < 85 ? pal_pkg::ACT_INSERT_LAST :
                       r < 88 ? pal_pkg::ACT_DELETE :
                       r < 91 ? pal_pkg::ACT_REPLACE :
                       r < 95 ? pal_pkg::ACT_SEARCH :
                       r < 99 ? pal_pkg::ACT_READ : pal_pkg::ACT_CLEAR;
            SHRINK_PHASE:
                return r < 6  ? pal_pkg::ACT_INSERT :
                       r < 9  ? pal_pkg::ACT_INSERT_FIRST :
                       r < 12 ? pal_pkg::ACT_INSERT_LAST :
                       r < 72 ? pal_pkg::ACT_DELETE :
                       r < 80 ? pal_pkg::ACT_REPLACE :
                       r < 88 ? pal_pkg::ACT_SEARCH :
                       r < 98 ? pal_pkg::ACT_READ : pal_pkg::ACT_CLEAR;
            default:
                return r < 12 ? pal_pkg::ACT_INSERT :
                       r < 20 ? pal_pkg::ACT_INSERT_FIRST :
                       r < 28 ? pal_pkg::ACT_INSERT_LAST :
                       r < 45 ? pal_pkg::ACT_DELETE :
                       r < 58 ? pal_pkg::ACT_REPLACE :
                       r < 75 ? pal_pkg::ACT_SEARCH :
                       r < 97 ? pal_pkg::ACT_READ : pal_pkg::ACT_CLEAR;
        endcase
    endfunction

    function automatic logic [7:0] pick_position();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 8'($urandom_range(0, 7));
        else if (r < 85)
            return 8'($urandom_range(0, 128));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 9) < 6)
            return value_pool[$urandom_range(0, 15)];
        return $urandom;
    endfunction

    initial
    begin : receiver
        stall_style_t style;
        int           seg;
        int           len;
        int           k;
        int           j;
        seg = 0;
        wait (rst_n);
        forever
        begin
            seg++;
            if (seg == 6)
            begin
                // long hold-off so the block backs up onto its input
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else
            begin
                style = stall_style_t'($urandom_range(0, 3));
                len   = $urandom_range(10, 200);
                k     = $urandom_range(2, 6);
                for (j = 0; j < len; j++)
                begin
                    case (style)
                        ALWAYS_READY: m_tready <= 1'b1;
                        COIN_FLIP:    m_tready <= 1'($urandom_range(0, 1));
                        EVERY_KTH:    m_tready <= (j % k == 0);
                        default:      m_tready <= ($urandom_range(0, 9) != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("positional_array_list_top_tb: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int     items_left;
        int     phase_idx;
        int     phase_len;
        int     k;
        phase_t phase;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hffff_ffff;
        value_pool[4] = 32'h0000_0001;
        for (k = 5; k < 16; k++)
            value_pool[k] = $urandom;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        offer_item(pal_pkg::ACT_SEARCH, 8'd0, 32'h0);
        offer_item(pal_pkg::ACT_READ, 8'd0, 32'h0);
        offer_item(pal_pkg::ACT_DELETE, 8'd255, 32'hffff_ffff);
        offer_item(pal_pkg::ACT_REPLACE, 8'd0, 32'h1234_5678);
        offer_item(pal_pkg::ACT_INSERT, 8'd1, 32'h1);
        offer_item(pal_pkg::ACT_INSERT, 8'd0, 32'h8000_0000);
        offer_item(pal_pkg::ACT_INSERT_LAST, 8'd200, 32'h7fff_ffff);
        offer_item(pal_pkg::ACT_INSERT_FIRST, 8'd77, 32'hffff_ffff);
        offer_item(pal_pkg::ACT_INSERT, 8'd255, 32'h5);
        offer_item(pal_pkg::ACT_INSERT, 8'd3, 32'h0);
        offer_item(pal_pkg::ACT_READ, 8'd3, 32'h0);
        offer_item(pal_pkg::ACT_READ, 8'd4, 32'h0);
        offer_item(pal_pkg::ACT_SEARCH, 8'd0, 32'h7fff_ffff);
        offer_item(pal_pkg::ACT_SEARCH, 8'd0, 32'h0000_3039);
        offer_item(pal_pkg::ACT_REPLACE, 8'd0, 32'h5555_5555);
        offer_item(pal_pkg::ACT_REPLACE, 8'd4, 32'haaaa_aaaa);
        offer_item(pal_pkg::ACT_READ, 8'd0, 32'h0);
        offer_item(pal_pkg::ACT_DELETE, 8'd1, 32'h0);
        offer_item(pal_pkg::ACT_DELETE, 8'd255, 32'h0);
        offer_item(pal_pkg::ACT_SEARCH, 8'd0, 32'h8000_0000);
        offer_item(pal_pkg::ACT_CLEAR, 8'd0, 32'h0);
        offer_item(pal_pkg::ACT_READ, 8'd0, 32'h0);
        offer_item(pal_pkg::ACT_INSERT_FIRST, 8'd0, 32'haaaa_aaaa);
        offer_item(pal_pkg::ACT_CLEAR, 8'd255, 32'hffff_ffff);

        items_left = RANDOM_ITEMS;
        phase_idx  = 0;
        while (items_left > 0)
        begin
            phase     = phase_t'(phase_idx % 3);
            phase_len = $urandom_range(150, 250);
            for (k = 0; k < phase_len && items_left > 0; k++)
            begin
                offer_item(pick_action(phase), pick_position(), pick_value());
                items_left--;
            end
            phase_idx++;
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("positional_array_list_top_tb: PASS");
        else
            $display("positional_array_list_top_tb: FAIL");
        $finish;
    end

endmodule

[files.f]
rtl/pal_pkg.sv
rtl/pal_cell.sv
rtl/pal_ctrl.sv
rtl/positional_array_list_top.sv
verif/list_result_checker.sv
verif/positional_array_list_top_tb.sv
